[rtl/latching_relay_pulse_controller_assert.svh]
// Assertion macros shared by the relay controller RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LATCHING_RELAY_PULSE_CONTROLLER_ASSERT_SVH
`define LATCHING_RELAY_PULSE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define LRPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LRPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRPC_ASSERT(lbl, prop, msg)
`define LRPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/lrpc_pkg.sv]
// Package for the latching relay pulse controller: beat types, codes,
// sizes and the tick-length load function. No dependencies.
package lrpc_pkg;

  localparam int NUM_RELAYS = 8;
  localparam int TIMER_BITS = 16;
  localparam int RIDX_W     = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  // Input action codes.
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ON     = 3'd1;
  localparam logic [2:0] ACT_OFF    = 3'd2;
  localparam logic [2:0] ACT_TOGGLE = 3'd3;
  localparam logic [2:0] ACT_DRIVE  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LATCHING    = 3'd0;
  localparam logic [2:0] CFG_ACTIVE_HIGH = 3'd1;
  localparam logic [2:0] CFG_ALLOW_SIM   = 3'd2;
  localparam logic [2:0] CFG_PULSE       = 3'd3;
  localparam logic [2:0] CFG_RETRY       = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_TICK   = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_TOGGLE = 3'd4,
    OP_DRIVE  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] relay_index;
    logic       level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] coil_on_pins;
    logic [7:0] coil_off_pins;
    logic [7:0] virtual_on;
    logic       notify;
    logic [2:0] notify_relay;
    logic       notify_state;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [RIDX_W-1:0] relay;
    logic              level;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  latching_mask;
    logic [7:0]  active_high_mask;
    logic        allow_simultaneous;
    logic [15:0] pulse_ticks;
    logic [15:0] retry_ticks;
  } cfg_t;

  // A length of zero counts as one tick; a length above the timer range saturates.
  function automatic logic [TIMER_BITS-1:0] load_ticks(logic [15:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w == 33'd0) w = 33'd1;
    if (w > TIMER_MAX) w = TIMER_MAX;
    return w[TIMER_BITS-1:0];
  endfunction

endpackage

[rtl/lrpc_front.sv]
// Front end: takes input beats, checks action and relay index and turns
// each beat into a command for the queue. Depends on lrpc_pkg.
module lrpc_front import lrpc_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic in_range;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign in_range = ({1'b0, in_data.relay_index} < 4'(NUM_RELAYS));

  always_comb begin
    q_cmd.relay = RIDX_W'(in_data.relay_index);
    q_cmd.level = in_data.level;
    case (in_data.action)
      ACT_TICK:   q_cmd.op = OP_TICK;
      ACT_ON:     q_cmd.op = OP_ON;
      ACT_OFF:    q_cmd.op = OP_OFF;
      ACT_TOGGLE: q_cmd.op = OP_TOGGLE;
      ACT_DRIVE:  q_cmd.op = OP_DRIVE;
      default:    q_cmd.op = OP_NOP;
    endcase
    // Commands addressed past the last relay do nothing but still answer.
    if (!in_range && (q_cmd.op != OP_TICK)) begin
      q_cmd.op = OP_NOP;
    end
  end

endmodule

[rtl/lrpc_cmdq.sv]
// Two-entry command queue between the front end and the execution unit.
// Depends on lrpc_pkg.
module lrpc_cmdq import lrpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/lrpc_back.sv]
// Execution unit: runs commands against the relay state, walks the relay
// timers one per cycle on a tick, and holds the result beat.
// Depends on lrpc_pkg and latching_relay_pulse_controller_assert.svh.
`include "latching_relay_pulse_controller_assert.svh"
module lrpc_back import lrpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } bk_state_t;

  bk_state_t st_r, st_nxt;
  logic [RIDX_W-1:0]     idx_r, idx_nxt;
  logic [NUM_RELAYS-1:0] virt_r, virt_nxt;
  logic [NUM_RELAYS-1:0] pend_r, pend_nxt;
  logic [NUM_RELAYS-1:0] onc_r, onc_nxt;
  logic [NUM_RELAYS-1:0] offc_r, offc_nxt;
  logic [NUM_RELAYS-1:0] armed_r, armed_nxt;
  logic [NUM_RELAYS-1:0] retry_r, retry_nxt;
  logic [TIMER_BITS-1:0] cnt_r [NUM_RELAYS];
  logic [TIMER_BITS-1:0] cnt_nxt [NUM_RELAYS];
  logic                  own_v_r, own_v_nxt;
  logic [RIDX_W-1:0]     own_r, own_nxt;
  logic                  ntf_r, ntf_nxt;
  logic [2:0]            ntf_rly_r, ntf_rly_nxt;
  logic                  ntf_st_r, ntf_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [NUM_RELAYS-1:0] ah;
  logic [NUM_RELAYS-1:0] latch;

  assign ah        = cfg.active_high_mask[NUM_RELAYS-1:0];
  assign latch     = cfg.latching_mask[NUM_RELAYS-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic              sp;
    logic              ep;
    logic              dl;
    logic              lvl;
    logic [RIDX_W-1:0] tr;

    sp            = 1'b0;
    ep            = 1'b0;
    dl            = 1'b0;
    lvl           = 1'b0;
    tr            = idx_r;
    q_pop         = 1'b0;
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    virt_nxt      = virt_r;
    pend_nxt      = pend_r;
    onc_nxt       = onc_r;
    offc_nxt      = offc_r;
    armed_nxt     = armed_r;
    retry_nxt     = retry_r;
    cnt_nxt       = cnt_r;
    own_v_nxt     = own_v_r;
    own_nxt       = own_r;
    ntf_nxt       = ntf_r;
    ntf_rly_nxt   = ntf_rly_r;
    ntf_st_nxt    = ntf_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          tr          = q_cmd.relay;
          ntf_nxt     = 1'b0;
          ntf_rly_nxt = 3'd0;
          ntf_st_nxt  = 1'b0;
          st_nxt      = ST_EMIT;
          case (q_cmd.op)
            OP_TICK: begin
              st_nxt  = ST_WALK;
              idx_nxt = '0;
            end
            OP_ON, OP_OFF, OP_TOGGLE: begin
              if (q_cmd.op == OP_ON) begin
                lvl = 1'b1;
              end else if (q_cmd.op == OP_OFF) begin
                lvl = 1'b0;
              end else begin
                lvl = !virt_r[tr];
              end
              virt_nxt[tr] = lvl;
              dl           = 1'b1;
              ntf_nxt      = 1'b1;
              ntf_rly_nxt  = 3'(tr);
              ntf_st_nxt   = lvl;
            end
            OP_DRIVE: begin
              dl  = 1'b1;
              lvl = q_cmd.level;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (armed_r[tr]) begin
          if (cnt_r[tr] > TIMER_BITS'(1)) begin
            cnt_nxt[tr] = cnt_r[tr] - TIMER_BITS'(1);
          end else begin
            cnt_nxt[tr]   = '0;
            armed_nxt[tr] = 1'b0;
            if (retry_r[tr]) begin
              sp = 1'b1;
            end else begin
              ep = 1'b1;
            end
          end
        end
        idx_nxt = RIDX_W'(idx_r + 1'b1);
        if (idx_r == RIDX_W'(NUM_RELAYS - 1)) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.coil_on_pins  = 8'(~(onc_r ^ ah));
          out_data_nxt.coil_off_pins = 8'(~(offc_r ^ ah) & latch);
          out_data_nxt.virtual_on    = 8'(virt_r);
          out_data_nxt.notify        = ntf_r;
          out_data_nxt.notify_relay  = ntf_rly_r;
          out_data_nxt.notify_state  = ntf_st_r;
          st_nxt                     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // A plain relay follows the level; a latching one restarts its pulse.
    if (dl) begin
      if (!latch[tr]) begin
        onc_nxt[tr] = lvl;
      end else begin
        pend_nxt[tr]  = lvl;
        armed_nxt[tr] = 1'b0;
        ep            = 1'b1;
        sp            = 1'b1;
      end
    end

    if (ep) begin
      onc_nxt[tr]  = 1'b0;
      offc_nxt[tr] = 1'b0;
      if (own_v_nxt && (own_nxt == tr)) begin
        own_v_nxt = 1'b0;
      end
    end

    if (sp) begin
      armed_nxt[tr] = 1'b1;
      if (!own_v_nxt || cfg.allow_simultaneous) begin
        if (pend_nxt[tr]) begin
          onc_nxt[tr] = 1'b1;
        end else begin
          offc_nxt[tr] = 1'b1;
        end
        own_v_nxt     = 1'b1;
        own_nxt       = tr;
        retry_nxt[tr] = 1'b0;
        cnt_nxt[tr]   = load_ticks(cfg.pulse_ticks);
      end else begin
        retry_nxt[tr] = 1'b1;
        cnt_nxt[tr]   = load_ticks(cfg.retry_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= '0;
      virt_r      <= '0;
      pend_r      <= '0;
      onc_r       <= '0;
      offc_r      <= '0;
      armed_r     <= '0;
      retry_r     <= '0;
      own_v_r     <= 1'b0;
      own_r       <= '0;
      ntf_r       <= 1'b0;
      ntf_rly_r   <= 3'd0;
      ntf_st_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      virt_r      <= virt_nxt;
      pend_r      <= pend_nxt;
      onc_r       <= onc_nxt;
      offc_r      <= offc_nxt;
      armed_r     <= armed_nxt;
      retry_r     <= retry_nxt;
      own_v_r     <= own_v_nxt;
      own_r       <= own_nxt;
      ntf_r       <= ntf_nxt;
      ntf_rly_r   <= ntf_rly_nxt;
      ntf_st_r    <= ntf_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // The slot owner always has a running pulse timer, never a retry.
  `LRPC_ASSERT(a_owner_pulsing, own_v_r |-> (armed_r[own_r] && !retry_r[own_r]), "owner without pulse")
  // The queue is only drained between items.
  `LRPC_ASSERT(a_pop_idle, q_pop |-> (st_r == ST_IDLE), "command taken while busy")
  // The walk always starts at relay zero.
  `LRPC_ASSERT(a_walk_start, (q_pop && (q_cmd.op == OP_TICK)) |=> (idx_r == '0), "bad walk start")
  `LRPC_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

[rtl/latching_relay_pulse_controller.sv]
// Top level of the latching relay pulse controller: configuration registers
// and the front end, command queue and execution unit. Depends on lrpc_pkg.
//
//  Port group  Direction  Handshake          Beat
//  in_*        input      in_valid/in_ready  in_item_t
//  out_*       output     out_valid/out_ready out_item_t
//  cfg_*       input      cfg_we             index 0..4, 16-bit data
//
// A command goes from the queue to the emit state, which registers its
// result; a tick first walks the relay timers, one relay per cycle.
// Up to two items queue ahead of the execution unit, so input is taken
// while a result waits. Reset is synchronous, active low, and needs no
// clearing pass. A stalled output holds the execution unit; the input
// stalls only once the queue is full.
module latching_relay_pulse_controller import lrpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LATCHING:    cfg_nxt.latching_mask      = cfg_wdata[7:0];
        CFG_ACTIVE_HIGH: cfg_nxt.active_high_mask   = cfg_wdata[7:0];
        CFG_ALLOW_SIM:   cfg_nxt.allow_simultaneous = cfg_wdata[0];
        CFG_PULSE:       cfg_nxt.pulse_ticks        = cfg_wdata;
        CFG_RETRY:       cfg_nxt.retry_ticks        = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.latching_mask      <= 8'd0;
      cfg_r.active_high_mask   <= 8'd255;
      cfg_r.allow_simultaneous <= 1'b0;
      cfg_r.pulse_ticks        <= 16'd100;
      cfg_r.retry_ticks        <= 16'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lrpc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lrpc_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  lrpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[verif/latching_relay_pulse_controller_test.sv]
// Self-checking testbench for latching_relay_pulse_controller: a scoreboard
// predicts every result beat while plain tasks drive the command and register
// ports. Depends on lrpc_pkg and the controller RTL.
module latching_relay_pulse_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lrpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RESET_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [15:0] RESET_PULSE_TICKS = 16'd100;
  localparam logic [15:0] RESET_RETRY_TICKS = 16'd50;
  localparam logic [2:0] ACT_UNDEF_LO = ACT_DRIVE + 3'd1;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  class coil_scoreboard;
    bit [7:0] latching;
    bit [7:0] active_high;
    bit allow_overlap;
    bit [15:0] pulse_len;
    bit [15:0] retry_len;
    bit [7:0] virt_on;
    bit [7:0] want_on;
    bit [7:0] on_coil;
    bit [7:0] off_coil;
    bit [7:0] armed;
    bit [7:0] retrying;
    bit [15:0] ticks_left [NUM_RELAYS];
    bit slot_taken;
    bit [2:0] slot_relay;
    out_item_t pins_due [$];
    int errors;

    function new();
      latching = '0;
      active_high = 8'hFF;
      allow_overlap = 1'b0;
      pulse_len = RESET_PULSE_TICKS;
      retry_len = RESET_RETRY_TICKS;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_LATCHING: latching = val[7:0];
        CFG_ACTIVE_HIGH: active_high = val[7:0];
        CFG_ALLOW_SIM: allow_overlap = val[0];
        CFG_PULSE: pulse_len = val;
        CFG_RETRY: retry_len = val;
        default: ;
      endcase
    endfunction

    // A zero length runs for one tick. Sixteen-bit lengths always fit the timer.
    function bit [15:0] timer_load(bit [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function void release_coils(int r);
      on_coil[r] = 1'b0;
      off_coil[r] = 1'b0;
      if (slot_taken && slot_relay == r) slot_taken = 1'b0;
    endfunction

    function void fire_coil(int r);
      armed[r] = 1'b1;
      if (!slot_taken || allow_overlap) begin
        if (want_on[r]) on_coil[r] = 1'b1;
        else off_coil[r] = 1'b1;
        slot_taken = 1'b1;
        slot_relay = r[2:0];
        retrying[r] = 1'b0;
        ticks_left[r] = timer_load(pulse_len);
      end else begin
        retrying[r] = 1'b1;
        ticks_left[r] = timer_load(retry_len);
      end
    endfunction

    function void set_contact(int r, bit lvl);
      if (!latching[r]) begin
        on_coil[r] = lvl;
      end else begin
        want_on[r] = lvl;
        release_coils(r);
        armed[r] = 1'b0;
        fire_coil(r);
      end
    endfunction

    // Expiries are handled lowest relay first, so a freed slot is visible
    // to a higher relay retrying in the same tick.
    function void advance_timers();
      for (int r = 0; r < NUM_RELAYS; r++) begin
        if (!armed[r]) continue;
        if (ticks_left[r] > 16'd1) begin
          ticks_left[r]--;
          continue;
        end
        ticks_left[r] = '0;
        armed[r] = 1'b0;
        if (retrying[r]) fire_coil(r);
        else release_coils(r);
      end
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t res;
      bit want;
      int r;
      r = cmd.relay_index;
      res = '0;
      case (cmd.action)
        ACT_TICK: advance_timers();
        ACT_ON, ACT_OFF, ACT_TOGGLE: begin
          if (cmd.action == ACT_ON) want = 1'b1;
          else if (cmd.action == ACT_OFF) want = 1'b0;
          else want = !virt_on[r];
          virt_on[r] = want;
          set_contact(r, want);
          res.notify = 1'b1;
          res.notify_relay = cmd.relay_index;
          res.notify_state = want;
        end
        ACT_DRIVE: set_contact(r, cmd.level);
        default: ;
      endcase
      res.coil_on_pins = ~(on_coil ^ active_high);
      res.coil_off_pins = ~(off_coil ^ active_high) & latching;
      res.virtual_on = virt_on;
      pins_due.push_back(res);
    endfunction

    function void field_check(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      if (pins_due.size() == 0) begin
        errors++;
        $display("%0t: result beat 0x%0h arrived with nothing expected", $time, got);
        return;
      end
      exp = pins_due.pop_front();
      field_check("coil_on_pins", exp.coil_on_pins, got.coil_on_pins);
      field_check("coil_off_pins", exp.coil_off_pins, got.coil_off_pins);
      field_check("virtual_on", exp.virtual_on, got.virtual_on);
      field_check("notify", 8'(exp.notify), 8'(got.notify));
      field_check("notify_relay", 8'(exp.notify_relay), 8'(got.notify_relay));
      field_check("notify_state", 8'(exp.notify_state), 8'(got.notify_state));
    endfunction

    function int outstanding();
      return pins_due.size();
    endfunction

    function void close_out();
      if (pins_due.size() != 0) begin
        errors += pins_due.size();
        $display("%0t: %0d expected results never arrived", $time, pins_due.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_LATCHING;
  logic [15:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;
  coil_scoreboard sb;

  latching_relay_pulse_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted beat, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("latching_relay_pulse_controller_test: errors");
      $finish;
    end
  end

  function automatic in_item_t make_cmd(logic [2:0] act, logic [2:0] r, logic lvl);
    in_item_t c;
    c.action = act;
    c.relay_index = r;
    c.level = lvl;
    return c;
  endfunction

  function automatic in_item_t random_cmd();
    int roll;
    logic [2:0] act;
    roll = $urandom_range(99);
    if (roll < 40) act = ACT_TICK;
    else if (roll < 95) act = ACT_ON + 3'($urandom_range(ACT_DRIVE - ACT_ON));
    else act = 3'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO));
    return make_cmd(act, 3'($urandom_range(NUM_RELAYS - 1)), 1'($urandom_range(1)));
  endfunction

  function automatic cfg_t random_cfg(int phase);
    cfg_t c;
    c.latching_mask = 8'($urandom_range(255));
    c.active_high_mask = 8'($urandom_range(255));
    c.allow_simultaneous = phase[0];
    c.pulse_ticks = 16'($urandom_range(6, 1));
    c.retry_ticks = 16'($urandom_range(4, 1));
    case (phase)
      1: begin
        c.latching_mask = 8'hFF;
        c.active_high_mask = 8'h00;
      end
      2: begin
        c.latching_mask = 8'h00;
        c.active_high_mask = 8'hFF;
      end
      5: begin
        c.latching_mask = 8'hFF;
        c.pulse_ticks = 16'hFFFF;
        c.retry_ticks = 16'hFFFF;
      end
      6: begin
        c.pulse_ticks = 16'd0;
        c.retry_ticks = 16'd0;
      end
      7: begin
        c.latching_mask = 8'hFF;
        c.retry_ticks = 16'd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Valid stays high into the next beat unless the sender decides to idle.
  task automatic send_command(in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_one(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(cfg_t c);
    write_one(CFG_LATCHING, 16'(c.latching_mask));
    write_one(CFG_ACTIVE_HIGH, 16'(c.active_high_mask));
    write_one(CFG_ALLOW_SIM, 16'(c.allow_simultaneous));
    write_one(CFG_PULSE, c.pulse_ticks);
    write_one(CFG_RETRY, c.retry_ticks);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Plain relays under the reset settings, plus the undefined action codes.
    send_command(make_cmd(ACT_ON, 3'd0, 1'b0));
    send_command(make_cmd(ACT_OFF, 3'd0, 1'b1));
    send_command(make_cmd(ACT_TOGGLE, 3'd7, 1'b0));
    send_command(make_cmd(ACT_TOGGLE, 3'd7, 1'b1));
    send_command(make_cmd(ACT_DRIVE, 3'd3, 1'b1));
    send_command(make_cmd(ACT_DRIVE, 3'd3, 1'b0));
    send_command(make_cmd(ACT_UNDEF_LO, 3'd5, 1'b1));
    send_command(make_cmd(ACT_UNDEF_LO + 3'd1, 3'd6, 1'b0));
    send_command(make_cmd(ACT_UNDEF_HI, 3'd7, 1'b1));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    settle();

    // All latching, mixed pin polarity, no overlap, zero pulse length:
    // a blocked pulse, its retry, and a relay ending its own pulse.
    c.latching_mask = 8'hFF;
    c.active_high_mask = 8'h0F;
    c.allow_simultaneous = 1'b0;
    c.pulse_ticks = 16'd0;
    c.retry_ticks = 16'd2;
    program_regs(c);
    send_command(make_cmd(ACT_ON, 3'd1, 1'b0));
    send_command(make_cmd(ACT_ON, 3'd2, 1'b0));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    send_command(make_cmd(ACT_DRIVE, 3'd2, 1'b0));
    send_command(make_cmd(ACT_TOGGLE, 3'd1, 1'b0));
    send_command(make_cmd(ACT_ON, 3'd3, 1'b0));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    send_command(make_cmd(ACT_DRIVE, 3'd0, 1'b1));
    send_command(make_cmd(ACT_TICK, 3'd0, 1'b0));
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      program_regs(random_cfg(phase));
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Mid-phase pressure: a long receiver hold-off that backs up the
        // input, and later a full drain before the sender resumes.
        if (i == ITEMS_PER_PHASE / 2 && phase == 0) hold_cycles = HOLD_OFF_CYCLES;
        if (i == ITEMS_PER_PHASE / 2 && phase == 4) settle();
        send_command(random_cmd());
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("latching_relay_pulse_controller_test: clean");
    end else begin
      $display("latching_relay_pulse_controller_test: errors");
    end
    $finish;
  end

endmodule
